// ===== rtl/dfs_pkg.sv =====
// dfs_pkg: shared types, register map and reset values of the delimiter frame splitter
// used by dfs_front, dfs_queue, dfs_back and delimiter_frame_splitter_unit
// no dependencies
package dfs_pkg;

  localparam int DELIM_SLOTS     = 4;
  localparam int DELIM_MAX_BYTES = 4;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_ADDR_W      = 5;
  localparam int SEEN_W          = 17;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_MAX_FRAME_LENGTH  = 3'd0;
  localparam reg_idx_t REG_STRIP_DELIMITER   = 3'd1;
  localparam reg_idx_t REG_DELIMITER_COUNT   = 3'd2;
  localparam reg_idx_t REG_DELIMITER_LENGTHS = 3'd3;
  localparam reg_idx_t REG_DELIMITER_ZERO    = 3'd4;
  localparam reg_idx_t REG_DELIMITER_ONE     = 3'd5;
  localparam reg_idx_t REG_DELIMITER_TWO     = 3'd6;
  localparam reg_idx_t REG_DELIMITER_THREE   = 3'd7;

  localparam logic [15:0] RST_MAX_FRAME_LENGTH  = 16'd8192;
  localparam logic        RST_STRIP_DELIMITER   = 1'b1;
  localparam logic [2:0]  RST_DELIMITER_COUNT   = 3'd2;
  localparam logic [7:0]  RST_DELIMITER_LENGTHS = 8'd1;
  // "\r\n" and "\n", first byte in the low bits
  localparam logic [31:0] RST_DELIMITER_ZERO    = 32'h0000_0A0D;
  localparam logic [31:0] RST_DELIMITER_ONE     = 32'h0000_000A;
  localparam logic [31:0] RST_DELIMITER_TWO     = 32'h0000_0000;
  localparam logic [31:0] RST_DELIMITER_THREE   = 32'h0000_0000;

  typedef struct packed {
    logic [15:0]      max_frame_length;
    logic             strip_delimiter;
    logic [2:0]       delimiter_count;
    logic [7:0]       delimiter_lengths;
    logic [3:0][31:0] delimiter_words;
  } cfg_t;

  // per-group control, shared by every item of a queued group (frame_end marks only the last)
  typedef struct packed {
    logic has_byte;
    logic frame_end;
    logic frame_status;
  } item_ctl_t;

endpackage

// ===== rtl/dfs_front.sv =====
// dfs_front: delimiter matching, hold-back of frame bytes and frame length tracking
// emits at most one group of up to P_MAX_BYTES+1 result items per accepted byte
// depends on dfs_pkg
module dfs_front #(
  parameter int P_SLOTS     = dfs_pkg::DELIM_SLOTS,
  parameter int P_MAX_BYTES = dfs_pkg::DELIM_MAX_BYTES,
  localparam int NB = P_MAX_BYTES + 1,
  localparam int CW = $clog2(NB + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dfs_pkg::cfg_t       cfg,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                desc_valid,
  output logic [NB-1:0][7:0]  desc_bytes,
  output logic [CW-1:0]       desc_cnt,
  output dfs_pkg::item_ctl_t  desc_ctl
);

  localparam int HW = $clog2(P_MAX_BYTES + 1);
  localparam int RD = (P_MAX_BYTES > 1) ? P_MAX_BYTES - 1 : 1;
  localparam int SW = dfs_pkg::SEEN_W;

  logic [RD-1:0][7:0]          recent_r, recent_nxt;
  logic [P_MAX_BYTES-1:0][7:0] held_r, held_nxt;
  logic [HW-1:0]               held_cnt_r, held_cnt_nxt;
  logic [SW-1:0]               seen_r, seen_nxt;
  logic                        disc_r, disc_nxt;

  logic [P_MAX_BYTES-1:0][7:0]         hist;
  logic [P_SLOTS-1:0][HW-1:0]          slot_len;
  logic [P_SLOTS-1:0][P_MAX_BYTES-1:0] slot_eq;
  logic [P_SLOTS-1:0]                  slot_hit;
  logic [2:0]                          active;
  logic [HW-1:0]                       best;
  logic [SW-1:0]                       seen_inc;
  logic [SW-1:0]                       flen;
  logic [HW-1:0]                       tail;
  logic                                too_long;

  // newest byte first: age 0 is the incoming byte
  always_comb begin
    hist[0] = in_byte;
    for (int a = 1; a < P_MAX_BYTES; a++) begin
      hist[a] = recent_r[a-1];
    end
  end

  assign active = (cfg.delimiter_count > 3'(P_SLOTS)) ? 3'(P_SLOTS) : cfg.delimiter_count;

  always_comb begin
    logic [2:0] raw;
    logic       eq;
    logic       sel;
    raw = 3'd0;
    eq  = 1'b0;
    sel = 1'b0;
    for (int k = 0; k < P_SLOTS; k++) begin
      raw = {1'b0, cfg.delimiter_lengths[2*k +: 2]} + 3'd1;
      slot_len[k] = (raw > 3'(P_MAX_BYTES)) ? HW'(P_MAX_BYTES) : HW'(raw);
      // compare the last L stream bytes against the first L delimiter bytes
      for (int l = 1; l <= P_MAX_BYTES; l++) begin
        eq = 1'b1;
        for (int j = 0; j < l; j++) begin
          if (cfg.delimiter_words[k][8*j +: 8] != hist[l-1-j]) begin
            eq = 1'b0;
          end
        end
        slot_eq[k][l-1] = eq;
      end
      sel = 1'b0;
      for (int l = 1; l <= P_MAX_BYTES; l++) begin
        if (slot_len[k] == HW'(l)) begin
          sel = slot_eq[k][l-1];
        end
      end
      // a match must lie wholly inside the current frame
      slot_hit[k] = (k < int'(active)) &&
                    (({1'b0, seen_r} + (SW+1)'(1)) >= (SW+1)'(slot_len[k])) && sel;
    end
  end

  // longest hit wins; on equal length only the length matters
  always_comb begin
    best = '0;
    for (int k = 0; k < P_SLOTS; k++) begin
      if (slot_hit[k] && (slot_len[k] > best)) begin
        best = slot_len[k];
      end
    end
  end

  assign seen_inc = (seen_r == {SW{1'b1}}) ? seen_r : seen_r + SW'(1);
  assign flen     = seen_r - SW'(best - HW'(1));
  assign tail     = (held_cnt_r >= (best - HW'(1))) ? held_cnt_r - (best - HW'(1)) : '0;
  assign too_long = disc_r || (flen > {1'b0, cfg.max_frame_length});

  always_comb begin
    recent_nxt   = recent_r;
    held_nxt     = held_r;
    held_cnt_nxt = held_cnt_r;
    seen_nxt     = seen_r;
    disc_nxt     = disc_r;
    desc_cnt     = '0;
    desc_ctl     = '0;
    // held bytes in order, the incoming byte right after the last held one
    for (int i = 0; i < P_MAX_BYTES; i++) begin
      desc_bytes[i] = (i < int'(held_cnt_r)) ? held_r[i] : in_byte;
    end
    desc_bytes[NB-1] = in_byte;

    if (in_valid) begin
      recent_nxt[0] = in_byte;
      for (int i = 1; i < RD; i++) begin
        recent_nxt[i] = recent_r[i-1];
      end

      if (best != '0) begin
        if (too_long) begin
          desc_cnt = CW'(1);
          desc_ctl = '{has_byte: 1'b0, frame_end: 1'b1, frame_status: 1'b1};
        end else if (cfg.strip_delimiter) begin
          if (tail == '0) begin
            desc_cnt = CW'(1);
            desc_ctl = '{has_byte: 1'b0, frame_end: 1'b1, frame_status: 1'b0};
          end else begin
            desc_cnt = CW'(tail);
            desc_ctl = '{has_byte: 1'b1, frame_end: 1'b1, frame_status: 1'b0};
          end
        end else begin
          desc_cnt = CW'(held_cnt_r) + CW'(1);
          desc_ctl = '{has_byte: 1'b1, frame_end: 1'b1, frame_status: 1'b0};
        end
        held_cnt_nxt = '0;
        seen_nxt     = '0;
        disc_nxt     = 1'b0;
      end else begin
        seen_nxt = seen_inc;
        if (!disc_r) begin
          if (held_cnt_r == HW'(P_MAX_BYTES)) begin
            for (int i = 0; i < P_MAX_BYTES - 1; i++) begin
              held_nxt[i] = held_r[i+1];
            end
            held_nxt[P_MAX_BYTES-1] = in_byte;
            if ((seen_inc - SW'(P_MAX_BYTES)) > {1'b0, cfg.max_frame_length}) begin
              disc_nxt     = 1'b1;
              held_cnt_nxt = '0;
            end else begin
              desc_cnt = CW'(1);
              desc_ctl = '{has_byte: 1'b1, frame_end: 1'b0, frame_status: 1'b0};
            end
          end else begin
            for (int i = 0; i < P_MAX_BYTES; i++) begin
              if (HW'(i) == held_cnt_r) begin
                held_nxt[i] = in_byte;
              end
            end
            held_cnt_nxt = held_cnt_r + HW'(1);
          end
        end
      end
    end
  end

  assign desc_valid = in_valid && (desc_cnt != '0);

  always_ff @(posedge clk) begin
    recent_r <= recent_nxt;
    held_r   <= held_nxt;
    if (!rst_n) begin
      held_cnt_r <= '0;
      seen_r     <= '0;
      disc_r     <= 1'b0;
    end else begin
      held_cnt_r <= held_cnt_nxt;
      seen_r     <= seen_nxt;
      disc_r     <= disc_nxt;
    end
  end

endmodule

// ===== rtl/dfs_queue.sv =====
// dfs_queue: short queue of result groups between front and back
// register storage, one write and one read slot per cycle
// depends on dfs_pkg
module dfs_queue #(
  parameter int P_DEPTH     = dfs_pkg::QUEUE_DEPTH,
  parameter int P_MAX_BYTES = dfs_pkg::DELIM_MAX_BYTES,
  localparam int NB = P_MAX_BYTES + 1,
  localparam int CW = $clog2(NB + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [NB-1:0][7:0]  push_bytes,
  input  logic [CW-1:0]       push_cnt,
  input  dfs_pkg::item_ctl_t  push_ctl,
  output logic                full,
  input  logic                pop,
  output logic [NB-1:0][7:0]  head_bytes,
  output logic [CW-1:0]       head_cnt,
  output dfs_pkg::item_ctl_t  head_ctl,
  output logic                empty
);

  localparam int PW = $clog2(P_DEPTH);
  localparam int KW = $clog2(P_DEPTH + 1);

  logic [NB-1:0][7:0] bytes_r [P_DEPTH];
  logic [CW-1:0]      cnt_r   [P_DEPTH];
  dfs_pkg::item_ctl_t ctl_r   [P_DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [KW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == KW'(P_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  assign head_bytes = bytes_r[rd_ptr_r];
  assign head_cnt   = cnt_r[rd_ptr_r];
  assign head_ctl   = ctl_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(P_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(P_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + KW'(1);
      2'b01:   count_nxt = count_r - KW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      bytes_r[wr_ptr_r] <= push_bytes;
      cnt_r[wr_ptr_r]   <= push_cnt;
      ctl_r[wr_ptr_r]   <= push_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= KW'(P_DEPTH))
    else $error("group queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + KW'(1)))
    else $error("group queue lost a push");
`endif

endmodule

// ===== rtl/dfs_back.sv =====
// dfs_back: unpacks queued groups into single result transactions
// walks the items of the head group, releases the group after its last item
// depends on dfs_pkg
module dfs_back #(
  parameter int P_MAX_BYTES = dfs_pkg::DELIM_MAX_BYTES,
  localparam int NB = P_MAX_BYTES + 1,
  localparam int CW = $clog2(NB + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [NB-1:0][7:0]  head_bytes,
  input  logic [CW-1:0]       head_cnt,
  input  dfs_pkg::item_ctl_t  head_ctl,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          out_byte,
  output logic                out_has_byte,
  output logic                out_frame_end,
  output logic                out_frame_status
);

  logic [CW-1:0] idx_r, idx_nxt;
  logic          is_last;
  logic [7:0]    sel_byte;
  logic          take;

  assign is_last = (idx_r == (head_cnt - CW'(1)));
  assign take    = pop && !q_empty;
  assign q_pop   = take && is_last;
  assign empty   = q_empty;

  always_comb begin
    sel_byte = '0;
    for (int i = 0; i < NB; i++) begin
      if (CW'(i) == idx_r) begin
        sel_byte = head_bytes[i];
      end
    end
  end

  assign out_byte         = head_ctl.has_byte ? sel_byte : 8'd0;
  assign out_has_byte     = head_ctl.has_byte;
  assign out_frame_end    = head_ctl.frame_end && is_last;
  assign out_frame_status = head_ctl.frame_status;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = is_last ? '0 : idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_marker_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && !head_ctl.has_byte) |-> (head_cnt == CW'(1)))
    else $error("marker group with more than one item");

  a_group_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !is_last) |=> !q_empty)
    else $error("group released before its last item");
`endif

endmodule

// ===== rtl/delimiter_frame_splitter_unit.sv =====
// delimiter_frame_splitter_unit: top level with the register file and the APB-style port
// instantiates dfs_front, dfs_queue and dfs_back; depends on dfs_pkg
//
// Usage: the byte stream enters on in_byte with push/full, one byte per cycle
// while full is low. Results leave on out_byte, out_has_byte, out_frame_end and
// out_frame_status; the oldest result is shown while empty is low and taken
// with pop. Each byte turns into zero to DELIM_MAX_BYTES+1 results: normally
// one delayed frame byte, at a delimiter the held frame tail (and delimiter
// bytes when not stripping) or a single marker. The results of a byte are
// registered in the group queue when it is accepted and drain at one per cycle
// while pop is high. Throughput is one byte per cycle; the front matching and hold
// logic handles a byte per cycle, and the group queue (QUEUE_DEPTH groups) absorbs
// the multi-item bursts at frame ends. When the receiver stalls, groups pile up in
// the queue and full rises once it holds QUEUE_DEPTH groups. Reset (rst_n low at a
// clock edge) empties the queue, clears the frame state and loads the register
// defaults: delimiters "\r\n" and "\n", stripping on, maximum frame length 8192.
// Registers must be written by the user only while the block is idle (unchecked).
module delimiter_frame_splitter_unit #(
  parameter int P_SLOTS     = dfs_pkg::DELIM_SLOTS,
  parameter int P_MAX_BYTES = dfs_pkg::DELIM_MAX_BYTES,
  parameter int P_DEPTH     = dfs_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     in_byte,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte,
  output logic                           out_has_byte,
  output logic                           out_frame_end,
  output logic                           out_frame_status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dfs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int NB = P_MAX_BYTES + 1;
  localparam int CW = $clog2(NB + 1);

  dfs_pkg::cfg_t     cfg_r, cfg_nxt;
  dfs_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  logic               accept;
  logic               desc_valid;
  logic [NB-1:0][7:0] desc_bytes;
  logic [CW-1:0]      desc_cnt;
  dfs_pkg::item_ctl_t desc_ctl;
  logic [NB-1:0][7:0] head_bytes;
  logic [CW-1:0]      head_cnt;
  dfs_pkg::item_ctl_t head_ctl;
  logic               q_empty;
  logic               q_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[dfs_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        dfs_pkg::REG_MAX_FRAME_LENGTH:  cfg_nxt.max_frame_length  = pwdata[15:0];
        dfs_pkg::REG_STRIP_DELIMITER:   cfg_nxt.strip_delimiter   = pwdata[0];
        dfs_pkg::REG_DELIMITER_COUNT:   cfg_nxt.delimiter_count   = pwdata[2:0];
        dfs_pkg::REG_DELIMITER_LENGTHS: cfg_nxt.delimiter_lengths = pwdata[7:0];
        dfs_pkg::REG_DELIMITER_ZERO:    cfg_nxt.delimiter_words[0] = pwdata;
        dfs_pkg::REG_DELIMITER_ONE:     cfg_nxt.delimiter_words[1] = pwdata;
        dfs_pkg::REG_DELIMITER_TWO:     cfg_nxt.delimiter_words[2] = pwdata;
        dfs_pkg::REG_DELIMITER_THREE:   cfg_nxt.delimiter_words[3] = pwdata;
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dfs_pkg::REG_MAX_FRAME_LENGTH:  prdata = {16'd0, cfg_r.max_frame_length};
      dfs_pkg::REG_STRIP_DELIMITER:   prdata = {31'd0, cfg_r.strip_delimiter};
      dfs_pkg::REG_DELIMITER_COUNT:   prdata = {29'd0, cfg_r.delimiter_count};
      dfs_pkg::REG_DELIMITER_LENGTHS: prdata = {24'd0, cfg_r.delimiter_lengths};
      dfs_pkg::REG_DELIMITER_ZERO:    prdata = cfg_r.delimiter_words[0];
      dfs_pkg::REG_DELIMITER_ONE:     prdata = cfg_r.delimiter_words[1];
      dfs_pkg::REG_DELIMITER_TWO:     prdata = cfg_r.delimiter_words[2];
      dfs_pkg::REG_DELIMITER_THREE:   prdata = cfg_r.delimiter_words[3];
      default:                        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_length   <= dfs_pkg::RST_MAX_FRAME_LENGTH;
      cfg_r.strip_delimiter    <= dfs_pkg::RST_STRIP_DELIMITER;
      cfg_r.delimiter_count    <= dfs_pkg::RST_DELIMITER_COUNT;
      cfg_r.delimiter_lengths  <= dfs_pkg::RST_DELIMITER_LENGTHS;
      cfg_r.delimiter_words[0] <= dfs_pkg::RST_DELIMITER_ZERO;
      cfg_r.delimiter_words[1] <= dfs_pkg::RST_DELIMITER_ONE;
      cfg_r.delimiter_words[2] <= dfs_pkg::RST_DELIMITER_TWO;
      cfg_r.delimiter_words[3] <= dfs_pkg::RST_DELIMITER_THREE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign accept = push && !full;

  dfs_front #(
    .P_SLOTS     (P_SLOTS),
    .P_MAX_BYTES (P_MAX_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (accept),
    .in_byte    (in_byte),
    .desc_valid (desc_valid),
    .desc_bytes (desc_bytes),
    .desc_cnt   (desc_cnt),
    .desc_ctl   (desc_ctl)
  );

  dfs_queue #(
    .P_DEPTH     (P_DEPTH),
    .P_MAX_BYTES (P_MAX_BYTES)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (desc_valid),
    .push_bytes (desc_bytes),
    .push_cnt   (desc_cnt),
    .push_ctl   (desc_ctl),
    .full       (full),
    .pop        (q_pop),
    .head_bytes (head_bytes),
    .head_cnt   (head_cnt),
    .head_ctl   (head_ctl),
    .empty      (q_empty)
  );

  dfs_back #(
    .P_MAX_BYTES (P_MAX_BYTES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_bytes       (head_bytes),
    .head_cnt         (head_cnt),
    .head_ctl         (head_ctl),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .pop              (pop),
    .empty            (empty),
    .out_byte         (out_byte),
    .out_has_byte     (out_has_byte),
    .out_frame_end    (out_frame_end),
    .out_frame_status (out_frame_status)
  );

endmodule

// ===== bench/dfs_checker.sv =====
`timescale 1ns / 1ps
// dfs_checker: watches the byte, result and register channels of the frame splitter,
// predicts each result from its own copy of the frame state and compares in order
// depends on dfs_pkg
module dfs_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic                           full,
  input  logic [7:0]                     in_byte,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [7:0]                     out_byte,
  input  logic                           out_has_byte,
  input  logic                           out_frame_end,
  input  logic                           out_frame_status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dfs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             pending
);

  localparam int SEEN_LIMIT = (1 << dfs_pkg::SEEN_W) - 1;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       frame_end;
    logic       frame_status;
  } frame_item_t;

  frame_item_t expected_items[$];

  dfs_pkg::cfg_t regs;
  logic [7:0]    recent [0:2];
  logic [7:0]    held [0:3];
  int            held_cnt;
  int            seen;
  logic          discarding;

  function automatic void add_item(logic [7:0] d, logic h, logic e, logic s);
    frame_item_t it;
    it.data = d;
    it.has_byte = h;
    it.frame_end = e;
    it.frame_status = s;
    expected_items.insert(expected_items.size(), it);
  endfunction

  // compares slot k of length len against the newest bytes, b being the newest
  function automatic bit delim_hit(int k, int len, logic [7:0] b);
    logic [7:0] want;
    logic [7:0] got;
    for (int j = 0; j < len; j++) begin
      want = regs.delimiter_words[k][8*j +: 8];
      got = (j == len - 1) ? b : recent[len - 2 - j];
      if (want != got) return 0;
    end
    return 1;
  endfunction

  task automatic split_byte(input logic [7:0] b);
    int active;
    int best;
    int len;
    int flen;
    int tail;
    int start_size;
    logic [7:0] oldest;
    active = (regs.delimiter_count > dfs_pkg::DELIM_SLOTS) ? dfs_pkg::DELIM_SLOTS
                                                           : int'(regs.delimiter_count);
    best = 0;
    for (int k = 0; k < active; k++) begin
      len = int'(regs.delimiter_lengths[2*k +: 2]) + 1;
      if (seen + 1 >= len && len > best && delim_hit(k, len, b)) best = len;
    end
    recent[2] = recent[1];
    recent[1] = recent[0];
    recent[0] = b;

    if (best > 0) begin
      flen = seen - (best - 1);
      if (discarding || flen > int'(regs.max_frame_length)) begin
        add_item(8'h00, 1'b0, 1'b1, 1'b1);
      end else begin
        tail = (held_cnt >= best - 1) ? held_cnt - (best - 1) : 0;
        start_size = expected_items.size();
        for (int i = 0; i < tail; i++) add_item(held[i], 1'b1, 1'b0, 1'b0);
        if (!regs.strip_delimiter) begin
          for (int i = tail; i < held_cnt; i++) add_item(held[i], 1'b1, 1'b0, 1'b0);
          add_item(b, 1'b1, 1'b0, 1'b0);
        end
        if (expected_items.size() == start_size) begin
          // empty frame with stripping still ends with a marker
          add_item(8'h00, 1'b0, 1'b1, 1'b0);
        end else begin
          expected_items[expected_items.size() - 1].frame_end = 1'b1;
        end
      end
      held_cnt = 0;
      seen = 0;
      discarding = 1'b0;
    end else begin
      if (seen < SEEN_LIMIT) seen++;
      if (!discarding) begin
        if (held_cnt >= dfs_pkg::DELIM_MAX_BYTES) begin
          oldest = held[0];
          held[0] = held[1];
          held[1] = held[2];
          held[2] = held[3];
          held[3] = b;
          if (seen - dfs_pkg::DELIM_MAX_BYTES > int'(regs.max_frame_length)) begin
            discarding = 1'b1;
            held_cnt = 0;
          end else begin
            add_item(oldest, 1'b1, 1'b0, 1'b0);
          end
        end else begin
          held[held_cnt] = b;
          held_cnt++;
        end
      end
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    frame_item_t want;
    if (!rst_n) begin
      regs.max_frame_length = dfs_pkg::RST_MAX_FRAME_LENGTH;
      regs.strip_delimiter = dfs_pkg::RST_STRIP_DELIMITER;
      regs.delimiter_count = dfs_pkg::RST_DELIMITER_COUNT;
      regs.delimiter_lengths = dfs_pkg::RST_DELIMITER_LENGTHS;
      regs.delimiter_words[0] = dfs_pkg::RST_DELIMITER_ZERO;
      regs.delimiter_words[1] = dfs_pkg::RST_DELIMITER_ONE;
      regs.delimiter_words[2] = dfs_pkg::RST_DELIMITER_TWO;
      regs.delimiter_words[3] = dfs_pkg::RST_DELIMITER_THREE;
      for (int i = 0; i < 3; i++) recent[i] = 8'h00;
      for (int i = 0; i < 4; i++) held[i] = 8'h00;
      held_cnt = 0;
      seen = 0;
      discarding = 1'b0;
      expected_items.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (dfs_pkg::reg_idx_t'(paddr[4:2]))
          dfs_pkg::REG_MAX_FRAME_LENGTH:  regs.max_frame_length = pwdata[15:0];
          dfs_pkg::REG_STRIP_DELIMITER:   regs.strip_delimiter = pwdata[0];
          dfs_pkg::REG_DELIMITER_COUNT:   regs.delimiter_count = pwdata[2:0];
          dfs_pkg::REG_DELIMITER_LENGTHS: regs.delimiter_lengths = pwdata[7:0];
          dfs_pkg::REG_DELIMITER_ZERO:    regs.delimiter_words[0] = pwdata;
          dfs_pkg::REG_DELIMITER_ONE:     regs.delimiter_words[1] = pwdata;
          dfs_pkg::REG_DELIMITER_TWO:     regs.delimiter_words[2] = pwdata;
          dfs_pkg::REG_DELIMITER_THREE:   regs.delimiter_words[3] = pwdata;
          default: ;
        endcase
      end
      if (push && !full) split_byte(in_byte);
      if (pop && !empty) begin
        if (expected_items.size() == 0) begin
          $error("result transaction with nothing expected: out_byte %0h has_byte %0b",
                 out_byte, out_has_byte);
          fail_count++;
        end else begin
          want = expected_items.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_has_byte", {7'd0, want.has_byte}, {7'd0, out_has_byte});
          check_field("out_frame_end", {7'd0, want.frame_end}, {7'd0, out_frame_end});
          check_field("out_frame_status", {7'd0, want.frame_status},
                      {7'd0, out_frame_status});
        end
      end
    end
    pending = expected_items.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for delimiter_frame_splitter_unit
// drives bytes, pops results and programs registers; dfs_checker does the comparing
// depends on dfs_pkg, delimiter_frame_splitter_unit and dfs_checker
module tb_top;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 6;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           push;
  logic                           full;
  logic [7:0]                     in_byte;
  logic                           empty;
  logic                           pop;
  logic [7:0]                     out_byte;
  logic                           out_has_byte;
  logic                           out_frame_end;
  logic                           out_frame_status;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [dfs_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;
  int                             fail_count;
  int                             pending;

  logic [7:0]    byte_q[$];
  dfs_pkg::cfg_t stim_cfg;
  bit            tx_idle_on;
  bit            rx_idle_on;
  int            hold_requests = 0;
  int            hold_served = 0;
  int            idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  delimiter_frame_splitter_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_byte(in_byte),
    .empty(empty), .pop(pop), .out_byte(out_byte), .out_has_byte(out_has_byte),
    .out_frame_end(out_frame_end), .out_frame_status(out_frame_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dfs_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_byte(in_byte),
    .empty(empty), .pop(pop), .out_byte(out_byte), .out_has_byte(out_has_byte),
    .out_frame_end(out_frame_end), .out_frame_status(out_frame_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("delimiter_frame_splitter_unit verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random pop bursts, plus the long hold-off on request
  initial begin
    pop = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_served != hold_requests) begin
        hold_served++;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        pop <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input dfs_pkg::reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apply_cfg(input dfs_pkg::cfg_t c);
    wait_drained();
    cfg_write(dfs_pkg::REG_MAX_FRAME_LENGTH, {16'd0, c.max_frame_length});
    cfg_write(dfs_pkg::REG_STRIP_DELIMITER, {31'd0, c.strip_delimiter});
    cfg_write(dfs_pkg::REG_DELIMITER_COUNT, {29'd0, c.delimiter_count});
    cfg_write(dfs_pkg::REG_DELIMITER_LENGTHS, {24'd0, c.delimiter_lengths});
    cfg_write(dfs_pkg::REG_DELIMITER_ZERO, c.delimiter_words[0]);
    cfg_write(dfs_pkg::REG_DELIMITER_ONE, c.delimiter_words[1]);
    cfg_write(dfs_pkg::REG_DELIMITER_TWO, c.delimiter_words[2]);
    cfg_write(dfs_pkg::REG_DELIMITER_THREE, c.delimiter_words[3]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    stim_cfg = c;
  endtask

  function automatic dfs_pkg::cfg_t random_cfg();
    dfs_pkg::cfg_t c;
    int r;
    r = $urandom_range(0, 9);
    c.max_frame_length = (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : 16'($urandom_range(2, 16));
    c.strip_delimiter = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 9);
    c.delimiter_count = (r < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(5, 8));
    c.delimiter_lengths = 8'($urandom_range(0, 255));
    for (int k = 0; k < 4; k++) c.delimiter_words[k] = $urandom();
    return c;
  endfunction

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_q.insert(byte_q.size(), s[i]);
  endtask

  // frames of random content, each closed by an active delimiter or a broken one, if any slot is active
  task automatic queue_frames(input int target);
    int active;
    int k;
    int len;
    int clen;
    int r;
    int dlen;
    logic [31:0] w;
    active = (stim_cfg.delimiter_count > dfs_pkg::DELIM_SLOTS) ? dfs_pkg::DELIM_SLOTS
                                                               : int'(stim_cfg.delimiter_count);
    while (byte_q.size() < target) begin
      r = $urandom_range(0, 9);
      clen = (r < 7) ? $urandom_range(0, 6) : (r < 9) ? $urandom_range(7, 14)
                                                      : $urandom_range(15, 20);
      k = (active > 0) ? $urandom_range(0, active - 1) : 0;
      len = int'(stim_cfg.delimiter_lengths[2*k +: 2]) + 1;
      w = stim_cfg.delimiter_words[k];
      for (int i = 0; i < clen; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          byte_q.insert(byte_q.size(), w[8*$urandom_range(0, len - 1) +: 8]);
        end else begin
          byte_q.insert(byte_q.size(), 8'($urandom_range(0, 255)));
        end
      end
      if (active > 0) begin
        dlen = ($urandom_range(0, 9) == 0) ? len - 1 : len;
        for (int i = 0; i < dlen; i++) byte_q.insert(byte_q.size(), w[8*i +: 8]);
      end
    end
  endtask

  task automatic send_all();
    logic [7:0] b;
    @(negedge clk);
    while (byte_q.size() > 0) begin
      b = byte_q.pop_front();
      if (tx_idle_on && $urandom_range(0, 7) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      push <= 1'b1;
      in_byte <= b;
      do @(posedge clk); while (full);
      @(negedge clk);
    end
    push <= 1'b0;
  endtask

  initial begin
    dfs_pkg::cfg_t c;
    rst_n = 1'b0;
    push = 1'b0;
    in_byte = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'h0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    stim_cfg.max_frame_length = dfs_pkg::RST_MAX_FRAME_LENGTH;
    stim_cfg.strip_delimiter = dfs_pkg::RST_STRIP_DELIMITER;
    stim_cfg.delimiter_count = dfs_pkg::RST_DELIMITER_COUNT;
    stim_cfg.delimiter_lengths = dfs_pkg::RST_DELIMITER_LENGTHS;
    stim_cfg.delimiter_words[0] = dfs_pkg::RST_DELIMITER_ZERO;
    stim_cfg.delimiter_words[1] = dfs_pkg::RST_DELIMITER_ONE;
    stim_cfg.delimiter_words[2] = dfs_pkg::RST_DELIMITER_TWO;
    stim_cfg.delimiter_words[3] = dfs_pkg::RST_DELIMITER_THREE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset delimiters: crlf frame, lone lf as empty frame, crlf at frame start
    queue_text("ab\015\012\012\015\012");
    send_all();

    // max length 1, delimiters kept: too long at delimiter, then discard, then good
    c = stim_cfg;
    c.max_frame_length = 16'd1;
    c.strip_delimiter = 1'b0;
    apply_cfg(c);
    queue_text("ab\012abcdef\012a\012");
    send_all();

    // overlapping delimiters of lengths 4, 4, 2, 1: longest then lower slot wins
    c.max_frame_length = 16'd100;
    c.strip_delimiter = 1'b1;
    c.delimiter_count = 3'd4;
    c.delimiter_lengths = 8'h1F;
    c.delimiter_words[0] = 32'h4443_4241;
    c.delimiter_words[1] = 32'h4443_4241;
    c.delimiter_words[2] = 32'h0000_4443;
    c.delimiter_words[3] = 32'h0000_0044;
    apply_cfg(c);
    queue_text("xABCDCD");
    send_all();

    // random settings, sender drains fully half way
    apply_cfg(random_cfg());
    queue_frames(6);
    send_all();
    wait_drained();
    queue_frames(6);
    send_all();

    // long delimiters kept, receiver holds off so the block backs up
    c = random_cfg();
    c.max_frame_length = 16'hFFFF;
    c.strip_delimiter = 1'b0;
    c.delimiter_count = 3'd4;
    c.delimiter_lengths = 8'hFF;
    apply_cfg(c);
    tx_idle_on = 1'b0;
    hold_requests++;
    queue_frames(25);
    send_all();
    tx_idle_on = 1'b1;

    // register extremes
    c = random_cfg();
    c.max_frame_length = 16'hFFFF;
    c.strip_delimiter = 1'b0;
    c.delimiter_count = 3'd7;
    c.delimiter_lengths = 8'hFF;
    c.delimiter_words[0] = 32'hFFFF_FFFF;
    c.delimiter_words[1] = 32'h0000_0000;
    apply_cfg(c);
    queue_frames(8);
    send_all();

    // no active delimiter: plain streaming through the hold
    c.strip_delimiter = 1'b1;
    c.delimiter_count = 3'd0;
    c.delimiter_lengths = 8'h00;
    for (int k = 0; k < 4; k++) c.delimiter_words[k] = 32'h0;
    apply_cfg(c);
    queue_frames(6);
    send_all();

    apply_cfg(random_cfg());
    queue_frames(10);
    send_all();

    // closing stretch at full rate
    apply_cfg(random_cfg());
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    queue_frames(10);
    send_all();

    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("delimiter_frame_splitter_unit verification clean");
    end else begin
      $display("delimiter_frame_splitter_unit verification failed");
    end
    $finish;
  end

endmodule
